### design/umpq_pkg.sv
// Shared types and constants for the unique min priority queue.
// Used by umpq_store, umpq_ctrl and the top level; depends on nothing else.
`default_nettype none

package umpq_pkg;

	// Default number of values the set can hold
	localparam int CAPACITY_DEF = 16;

	// Payload widths fixed by the stream format
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 5;

	// Value reported on every push and on a pop of an empty set
	localparam logic signed [VAL_W-1:0] POP_NONE = -32'sd1;

	// Item kind carried in the input tuser
	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	// Result status carried in the output tuser
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SRCH_CMP,
		S_SHIFT,
		S_SHIFT_WR,
		S_POP_WAIT,
		S_RESP
	} state_t;

	// Memory strobes from the sequencer to the entry store
	typedef struct packed {
		logic rd;
		logic wr;
		logic adv;
	} mem_cmd_t;

endpackage

`default_nettype wire

### design/umpq_store.sv
// Entry store: circular sorted buffer in one synchronous memory plus head pointer.
// Logical indices are relative to the head; depends on umpq_pkg.
`default_nettype none

module umpq_store
	import umpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mem_cmd_t                cmd,
	input  wire logic [IDX_W-1:0]        rd_idx,
	input  wire logic [IDX_W-1:0]        wr_idx,
	input  wire logic signed [VAL_W-1:0] wr_data,
	output logic signed [VAL_W-1:0]      rd_data
);

	localparam logic [IDX_W:0] CAP_EXT  = (IDX_W+1)'(CAPACITY);
	localparam logic [IDX_W:0] ONE_EXT  = (IDX_W+1)'(1);

	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic [IDX_W-1:0]        head_q;
	logic [IDX_W:0]          rd_sum;
	logic [IDX_W:0]          wr_sum;
	logic [IDX_W:0]          hd_sum;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        wr_addr;
	logic [IDX_W-1:0]        head_nxt;

	// Map logical index to physical address; the sum stays below twice the depth
	always_comb begin
		rd_sum = {1'b0, head_q} + {1'b0, rd_idx};
		wr_sum = {1'b0, head_q} + {1'b0, wr_idx};
		hd_sum = {1'b0, head_q} + ONE_EXT;
		rd_addr  = (rd_sum >= CAP_EXT) ? IDX_W'(rd_sum - CAP_EXT) : rd_sum[IDX_W-1:0];
		wr_addr  = (wr_sum >= CAP_EXT) ? IDX_W'(wr_sum - CAP_EXT) : wr_sum[IDX_W-1:0];
		head_nxt = (hd_sum >= CAP_EXT) ? IDX_W'(hd_sum - CAP_EXT) : hd_sum[IDX_W-1:0];
	end

	// Advance head when the smallest entry leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (cmd.adv) begin
			head_q <= head_nxt;
		end
	end

	// Memory: one write and one registered read per cycle; the sequencer never
	// reads and writes the same entry in one cycle
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/umpq_ctrl.sv
// Sequencer: binary search for the insert point, shift of the upper entries,
// pop of the head entry and the result fields; depends on umpq_pkg.
`default_nettype none

module umpq_ctrl
	import umpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire action_t                 in_action,
	input  wire logic signed [VAL_W-1:0] in_value,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output logic signed [VAL_W-1:0]      res_value,
	output status_t                      res_status,
	output logic [CNT_W-1:0]             res_count,
	output mem_cmd_t                     cmd,
	output logic [IDX_W-1:0]             rd_idx,
	output logic [IDX_W-1:0]             wr_idx,
	output logic signed [VAL_W-1:0]      wr_data,
	input  wire logic signed [VAL_W-1:0] rd_data
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	state_t                  state_q;
	state_t                  state_nxt;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi_q;
	logic [CNT_W-1:0]        sh_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    dup_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] pop_q;
	status_t                 status_q;
	logic [CNT_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid_w;
	logic [CNT_W-1:0]        sh_dec;
	logic                    accept;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[IDX_W:1];
	assign sh_dec  = sh_q - ONE_CNT;
	assign accept  = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_action == ACT_POP) begin
						state_nxt = (cnt_q == '0) ? S_RESP : S_POP_WAIT;
					end else begin
						state_nxt = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					state_nxt = S_SRCH_CMP;
				end else if (dup_q || cnt_q >= CAP_CNT) begin
					state_nxt = S_RESP;
				end else begin
					state_nxt = S_SHIFT;
				end
			end
			S_SRCH_CMP: state_nxt = S_SRCH;
			S_SHIFT: begin
				state_nxt = (sh_q > lo_q) ? S_SHIFT_WR : S_RESP;
			end
			S_SHIFT_WR: state_nxt = S_SHIFT;
			S_POP_WAIT: state_nxt = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs and memory strobes
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		cmd       = '0;
		rd_idx    = '0;
		wr_idx    = '0;
		wr_data   = val_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_action == ACT_POP && cnt_q != '0) begin
					cmd.rd = 1'b1;
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					cmd.rd = 1'b1;
					rd_idx = mid_w;
				end
			end
			S_SHIFT: begin
				if (sh_q > lo_q) begin
					cmd.rd = 1'b1;
					rd_idx = sh_dec[IDX_W-1:0];
				end else begin
					cmd.wr = 1'b1;
					wr_idx = lo_q[IDX_W-1:0];
				end
			end
			S_SHIFT_WR: begin
				cmd.wr  = 1'b1;
				wr_idx  = sh_q[IDX_W-1:0];
				wr_data = rd_data;
			end
			S_POP_WAIT: cmd.adv = 1'b1;
			S_RESP:     res_valid = 1'b1;
			default: ;
		endcase
	end

	// State and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_SHIFT && !(sh_q > lo_q)) begin
				cnt_q <= cnt_q + ONE_CNT;
			end else if (state_q == S_POP_WAIT) begin
				cnt_q <= cnt_q - ONE_CNT;
			end
		end
	end

	// Search bounds, shift pointer and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q    <= in_value;
					lo_q     <= '0;
					hi_q     <= cnt_q;
					sh_q     <= cnt_q;
					dup_q    <= 1'b0;
					pop_q    <= POP_NONE;
					status_q <= (in_action == ACT_POP && cnt_q == '0) ? ST_EMPTY : ST_DONE;
				end
			end
			S_SRCH: begin
				mid_q <= mid_w;
				if (!(lo_q < hi_q)) begin
					if (dup_q) begin
						status_q <= ST_DUP;
					end else if (cnt_q >= CAP_CNT) begin
						status_q <= ST_FULL;
					end
				end
			end
			S_SRCH_CMP: begin
				if (rd_data < val_q) begin
					lo_q <= CNT_W'(mid_q) + ONE_CNT;
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
				if (rd_data == val_q) begin
					dup_q <= 1'b1;
				end
			end
			S_SHIFT_WR: sh_q <= sh_dec;
			S_POP_WAIT: pop_q <= rd_data;
			default: ;
		endcase
	end

	assign res_value  = pop_q;
	assign res_status = status_q;
	assign res_count  = cnt_q;

endmodule

`default_nettype wire

### design/unique_min_priority_queue.sv
// Ordered set of distinct signed 32-bit values with push and pop-minimum on a
// stream interface. Values live sorted in a circular buffer in one synchronous
// memory; a head pointer makes a pop a single read. An item is taken only while
// the sequencer is idle; a finished result waits in the output register, so the
// next item can be taken before the result transfers. A pop reads the head
// entry as it is taken, then advances the head; an empty set goes straight to
// the result. A push runs binary-search probes (about log2 of the count plus
// one), each a read then a compare, moves each entry above the insert point by
// a read then a write, then writes the value unless already held or full; this
// order comes from the single memory port and its registered read. No clearing
// pass is needed after reset. Depends on umpq_pkg, umpq_store and umpq_ctrl.
`default_nettype none

module unique_min_priority_queue
	import umpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [0:0]  s_tuser,   // [0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] popped_value, [36:32] entry_count, zero fill
	output logic [1:0]       m_tuser    // [1:0] status
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	mem_cmd_t                cmd;
	logic [IDX_W-1:0]        rd_idx;
	logic [IDX_W-1:0]        wr_idx;
	logic signed [VAL_W-1:0] wr_data;
	logic signed [VAL_W-1:0] rd_data;
	logic                    res_valid;
	logic                    res_ready;
	logic signed [VAL_W-1:0] res_value;
	status_t                 res_status;
	logic [CNT_W-1:0]        res_count;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
	logic                    m_valid_q;
	logic signed [VAL_W-1:0] m_value_q;
	logic [CNT_OUT_W-1:0]    m_count_q;
	status_t                 m_status_q;

	umpq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (action_t'(s_tuser[0])),
		.in_value  (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_value (res_value),
		.res_status(res_status),
		.res_count (res_count),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.rd_data   (rd_data)
	);

	umpq_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_idx (rd_idx),
		.wr_idx (wr_idx),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	// Mask the count to the reported width
	assign cnt_ext   = {{CNT_OUT_W{1'b0}}, res_count};
	assign res_ready = !m_valid_q || m_tready;

	// Output register: load a finished result, drop the flag once it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_value_q  <= res_value;
			m_count_q  <= cnt_ext[CNT_OUT_W-1:0];
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_count_q, m_value_q};
	assign m_tuser  = m_status_q;

endmodule

`default_nettype wire
